### sv/psrs_pkg.sv
// shared types and constants of the prime sieve with row statistics
package psrs_pkg;

    localparam int NUM_W     = 16;
    localparam int LIMIT_W   = 16;
    localparam int DIGIT_W   = 4;
    localparam int RCNT_W    = 7;
    localparam int TOTAL_W   = 13;
    localparam int START_W   = 16;
    localparam int DEC_BASE  = 10;
    localparam int FIRST_PRIME = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

    localparam logic REQ_RUN   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_RANGE    = 2'd1,
        STS_UNSIEVED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_CHK_RD,
        S_CHK,
        S_CROSS,
        S_CNT,
        S_DRAIN,
        S_FIN,
        S_Q_RD,
        S_Q_OUT
    } t_state;

    typedef struct packed {
        logic             req_type;
        logic [NUM_W-1:0] number;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic               is_prime;
        logic [DIGIT_W-1:0] last_digit;
        logic [RCNT_W-1:0]  row_count;
        logic [TOTAL_W-1:0] prime_count;
        logic [RCNT_W-1:0]  min_row_count;
        logic [START_W-1:0] min_row_start;
        logic [RCNT_W-1:0]  max_row_count;
        logic [START_W-1:0] max_row_start;
    } t_res;

endpackage

### sv/psrs_qdiv.sv
// query number split into row index and decimal last digit by reciprocal multiply
module psrs_qdiv #(
    parameter int ROW_SIZE = 100,
    parameter int ROW_W    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic [psrs_pkg::NUM_W-1:0] i_number,
    output logic [psrs_pkg::NUM_W-1:0] o_number,
    output logic [ROW_W-1:0]          o_row,
    output logic [psrs_pkg::DIGIT_W-1:0] o_digit
);
    import psrs_pkg::*;

    // m = floor(2^(n+l)/d) + 1 with l = clog2(d) is exact for every n-bit numerator
    localparam int MW     = NUM_W + 1;
    localparam int PW     = NUM_W + MW;
    localparam int ROW_L  = $clog2(ROW_SIZE);
    localparam int ROW_SH = NUM_W + ROW_L;
    localparam logic [MW-1:0] ROW_M = MW'(((64'd1 << ROW_SH) / ROW_SIZE) + 64'd1);
    localparam int TEN_L  = $clog2(DEC_BASE);
    localparam int TEN_SH = NUM_W + TEN_L;
    localparam logic [MW-1:0] TEN_M = MW'(((64'd1 << TEN_SH) / DEC_BASE) + 64'd1);

    logic [PW-1:0]      w_row_prod;
    logic [PW-1:0]      w_ten_prod;
    logic [NUM_W-1:0]   w_ten_back;
    logic [NUM_W-1:0]   r_number;
    logic [ROW_W-1:0]   r_row;
    logic [NUM_W-1:0]   r_ten;
    logic [DIGIT_W-1:0] r_digit;

    assign w_row_prod = PW'(i_number) * PW'(ROW_M);
    assign w_ten_prod = PW'(i_number) * PW'(TEN_M);
    // quotient times ten as shift and add
    assign w_ten_back = NUM_W'({r_ten, 3'b000}) + NUM_W'({r_ten, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_number <= i_number;
            r_row    <= ROW_W'(w_row_prod >> ROW_SH);
            r_ten    <= NUM_W'(w_ten_prod >> TEN_SH);
        end
        r_digit <= DIGIT_W'(r_number - w_ten_back);
    end

    assign o_number = r_number;
    assign o_row    = r_row;
    assign o_digit  = r_digit;

endmodule

### sv/prime_sieve_with_row_stats.sv
// prime sieve with per-row prime counts, min and max rows, and number queries
// query: start transfer, S_Q_RD, S_Q_OUT, registered result strobe; next item taken in S_Q_OUT
// run: fill the bitmap up to the limit, then read and check each candidate up to sqrt(limit)
//   with one write per crossed-off multiple of each prime, then count and report the rows
// reset: limit goes to 100, statistics and the sieved flag clear; bitmap and row store are not
//   cleared and need no clearing pass; results cannot be stalled by the receiver
module prime_sieve_with_row_stats #(
    parameter int MAX_N    = 65536,
    parameter int ROW_SIZE = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  psrs_pkg::t_req              i_req,
    output logic                        o_valid,
    output psrs_pkg::t_res              o_res,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [psrs_pkg::LIMIT_W-1:0] i_cfg_data
);
    import psrs_pkg::*;

    localparam int AW        = $clog2(MAX_N);
    localparam int LW        = AW + 1;
    localparam int ROW_SLOTS = MAX_N / ROW_SIZE + 1;
    localparam int RW        = $clog2(ROW_SLOTS);
    localparam int CW        = $clog2(ROW_SIZE + 1);
    localparam int OW        = $clog2(ROW_SIZE);

    logic           mem_map [MAX_N];
    logic [CW-1:0]  mem_row [ROW_SLOTS];

    t_state r_state, n_state;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic [AW-1:0]      r_lim, n_lim;
    logic               r_sieved, n_sieved;
    logic [AW-1:0]      r_a, n_a;
    logic [AW-1:0]      r_i, n_i;
    logic [LW-1:0]      r_sq, n_sq;
    logic [LW-1:0]      r_j, n_j;
    logic [OW-1:0]      r_aoff, n_aoff;
    logic [RW-1:0]      r_arow, n_arow;
    logic [LW-1:0]      r_abase, n_abase;
    logic               r_d_v, n_d_v;
    logic               r_d_end, n_d_end;
    logic [RW-1:0]      r_d_row, n_d_row;
    logic [LW-1:0]      r_d_base, n_d_base;
    logic [CW-1:0]      r_rcnt, n_rcnt;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CW-1:0]      r_min_cnt, n_min_cnt;
    logic [START_W-1:0] r_min_start, n_min_start;
    logic [CW-1:0]      r_max_cnt, n_max_cnt;
    logic [START_W-1:0] r_max_start, n_max_start;
    t_res               r_res, n_res;
    logic               r_valid, n_valid;
    logic               r_map_rd;
    logic [CW-1:0]      r_row_rd;

    logic               w_free;
    logic               w_acc;
    logic [AW-1:0]      w_lim_clamp;
    logic               w_map_we;
    logic [AW-1:0]      w_map_waddr;
    logic               w_map_wd;
    logic [AW-1:0]      w_map_raddr;
    logic               w_row_we;
    logic [CW-1:0]      w_cnt;
    logic [START_W-1:0] w_rstart;

    logic [NUM_W-1:0]   qd_number;
    logic [RW-1:0]      qd_row;
    logic [DIGIT_W-1:0] qd_digit;

    psrs_qdiv #(
        .ROW_SIZE (ROW_SIZE),
        .ROW_W    (RW)
    ) u_qdiv (
        .i_clk    (i_clk),
        .i_load   (w_acc),
        .i_number (i_req.number),
        .o_number (qd_number),
        .o_row    (qd_row),
        .o_digit  (qd_digit)
    );

    // a new item may enter while the previous result is being presented
    assign w_free = (r_state == S_IDLE) || (r_state == S_Q_OUT) || (r_state == S_FIN);
    assign busy        = !w_free;
    assign o_cfg_ready = w_free;
    assign w_acc       = start && w_free;

    assign w_lim_clamp = (32'(r_limit) > 32'(MAX_N - 1)) ? AW'(MAX_N - 1) : AW'(r_limit);
    assign w_cnt       = r_rcnt + CW'(r_map_rd);
    assign w_rstart    = (r_d_row == '0) ? START_W'(FIRST_PRIME) : START_W'(r_d_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_lim       = r_lim;
        n_sieved    = r_sieved;
        n_a         = r_a;
        n_i         = r_i;
        n_sq        = r_sq;
        n_j         = r_j;
        n_aoff      = r_aoff;
        n_arow      = r_arow;
        n_abase     = r_abase;
        n_d_v       = 1'b0;
        n_d_end     = r_d_end;
        n_d_row     = r_d_row;
        n_d_base    = r_d_base;
        n_rcnt      = r_rcnt;
        n_total     = r_total;
        n_min_cnt   = r_min_cnt;
        n_min_start = r_min_start;
        n_max_cnt   = r_max_cnt;
        n_max_start = r_max_start;
        n_res       = r_res;
        n_valid     = 1'b0;
        w_map_we    = 1'b0;
        w_map_waddr = r_a;
        w_map_wd    = 1'b0;
        w_map_raddr = r_a;
        w_row_we    = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_limit = i_cfg_data;
        end

        // count pass data stage, in the cycle after the bitmap read
        if (r_d_v) begin
            n_total = r_total + TOTAL_W'(r_map_rd);
            if (r_d_end) begin
                w_row_we = 1'b1;
                n_rcnt   = '0;
                if (r_d_row == '0) begin
                    n_min_cnt   = w_cnt;
                    n_min_start = w_rstart;
                    n_max_cnt   = w_cnt;
                    n_max_start = w_rstart;
                end else begin
                    if (w_cnt < r_min_cnt) begin
                        n_min_cnt   = w_cnt;
                        n_min_start = w_rstart;
                    end
                    if (w_cnt > r_max_cnt) begin
                        n_max_cnt   = w_cnt;
                        n_max_start = w_rstart;
                    end
                end
            end else begin
                n_rcnt = w_cnt;
            end
        end

        case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_INIT: begin
                w_map_we    = 1'b1;
                w_map_waddr = r_a;
                w_map_wd    = 1'b1;
                if (r_a == r_lim) begin
                    n_i     = AW'(FIRST_PRIME);
                    n_sq    = LW'(FIRST_PRIME * FIRST_PRIME);
                    n_state = S_CHK_RD;
                end else begin
                    n_a = r_a + AW'(1);
                end
            end
            S_CHK_RD: begin
                w_map_raddr = r_i;
                if (r_sq > LW'(r_lim)) begin
                    n_a     = AW'(FIRST_PRIME);
                    n_aoff  = OW'(FIRST_PRIME);
                    n_arow  = '0;
                    n_abase = '0;
                    n_state = S_CNT;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_map_rd) begin
                    n_j     = r_sq;
                    n_state = S_CROSS;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_sq    = r_sq + LW'({r_i, 1'b1});
                    n_state = S_CHK_RD;
                end
            end
            S_CROSS: begin
                if (r_j > LW'(r_lim)) begin
                    n_i     = r_i + AW'(1);
                    n_sq    = r_sq + LW'({r_i, 1'b1});
                    n_state = S_CHK_RD;
                end else begin
                    w_map_we    = 1'b1;
                    w_map_waddr = r_j[AW-1:0];
                    w_map_wd    = 1'b0;
                    n_j         = r_j + LW'(r_i);
                end
            end
            S_CNT: begin
                w_map_raddr = r_a;
                n_d_v       = 1'b1;
                n_d_end     = (r_a == r_lim) || (r_aoff == OW'(ROW_SIZE - 1));
                n_d_row     = r_arow;
                n_d_base    = r_abase;
                n_a         = r_a + AW'(1);
                if (r_aoff == OW'(ROW_SIZE - 1)) begin
                    n_aoff  = '0;
                    n_arow  = r_arow + RW'(1);
                    n_abase = r_abase + LW'(ROW_SIZE);
                end else begin
                    n_aoff  = r_aoff + OW'(1);
                end
                if (r_a == r_lim) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_valid = 1'b1;
                n_res   = '0;
                n_res.status = STS_OK;
                n_state = S_IDLE;
            end
            S_Q_RD: begin
                w_map_raddr = AW'(qd_number);
                n_state     = S_Q_OUT;
            end
            S_Q_OUT: begin
                n_valid = 1'b1;
                n_res   = '0;
                if (!r_sieved) begin
                    n_res.status = STS_UNSIEVED;
                end else if (32'(qd_number) > 32'(r_lim)) begin
                    n_res.status = STS_RANGE;
                end else begin
                    n_res.status = STS_OK;
                    // zero and one are never prime, whatever the bitmap holds
                    n_res.is_prime = r_map_rd && (qd_number >= NUM_W'(FIRST_PRIME));
                    n_res.last_digit = n_res.is_prime ? qd_digit : '0;
                    n_res.row_count = (r_lim < AW'(FIRST_PRIME)) ? '0 : RCNT_W'(r_row_rd);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_valid) begin
            n_res.prime_count   = r_total;
            n_res.min_row_count = RCNT_W'(r_min_cnt);
            n_res.min_row_start = r_min_start;
            n_res.max_row_count = RCNT_W'(r_max_cnt);
            n_res.max_row_start = r_max_start;
        end

        if (w_acc) begin
            if (i_req.req_type == REQ_QUERY) begin
                n_state = S_Q_RD;
            end else begin
                n_lim       = w_lim_clamp;
                n_sieved    = 1'b1;
                n_total     = '0;
                n_min_cnt   = '0;
                n_max_cnt   = '0;
                n_min_start = START_W'(FIRST_PRIME);
                n_max_start = START_W'(FIRST_PRIME);
                n_rcnt      = '0;
                n_a         = '0;
                n_state     = (w_lim_clamp < AW'(FIRST_PRIME)) ? S_FIN : S_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_lim       <= '0;
            r_sieved    <= 1'b0;
            r_total     <= '0;
            r_min_cnt   <= '0;
            r_min_start <= '0;
            r_max_cnt   <= '0;
            r_max_start <= '0;
            r_d_v       <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_limit     <= n_limit;
            r_lim       <= n_lim;
            r_sieved    <= n_sieved;
            r_total     <= n_total;
            r_min_cnt   <= n_min_cnt;
            r_min_start <= n_min_start;
            r_max_cnt   <= n_max_cnt;
            r_max_start <= n_max_start;
            r_d_v       <= n_d_v;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_i      <= n_i;
        r_sq     <= n_sq;
        r_j      <= n_j;
        r_aoff   <= n_aoff;
        r_arow   <= n_arow;
        r_abase  <= n_abase;
        r_d_end  <= n_d_end;
        r_d_row  <= n_d_row;
        r_d_base <= n_d_base;
        r_rcnt   <= n_rcnt;
        r_res    <= n_res;
    end

    // prime bitmap, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            mem_map[w_map_waddr] <= w_map_wd;
        end
        r_map_rd <= mem_map[w_map_raddr];
    end

    // per-row prime counts
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            mem_row[r_d_row] <= w_cnt;
        end
        r_row_rd <= mem_row[qd_row];
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.req_type == REQ_QUERY)) |-> ##3 o_valid)
        else $error("query transfer did not produce a result three cycles later");

    a_row_write_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_we |-> ((r_state == S_CNT) || (r_state == S_DRAIN)))
        else $error("row store written outside the count pass");

    a_map_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_map_we |-> (32'(w_map_waddr) <= 32'(r_lim)))
        else $error("bitmap written above the run limit");

    a_sieved_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sieved |=> r_sieved)
        else $error("sieved flag dropped without reset");

endmodule
